[rtl/rgbc3_pkg.sv]
`default_nettype none

package rgbc3_pkg;

    localparam int LINE_DEPTH = 1024;

    localparam int PIX_W  = 24;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 10;
    localparam int CH_W   = 20;
    localparam int DATA_W = 88;

    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + ROW_W;
    localparam int RED_LSB   = COL_LSB + COL_W;
    localparam int GREEN_LSB = RED_LSB + CH_W;
    localparam int BLUE_LSB  = GREEN_LSB + CH_W;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_NORM   = 3'd2,
        CFG_KTOP   = 3'd3,
        CFG_KMID   = 3'd4,
        CFG_KBOT   = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MAC  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/rgb_conv3x3_normalized.sv]
// each accepted word gets a line memory read, then, for each centre that it completes, the taps
//   one at a time, a divide of the sums if normalizing a nonzero tap sum, and a result word load
// no new word is taken until the last one is through, and a stalled result word holds the flow;
//   the single-port line memory and the shared tap multiply/divide unit serve one word at a time
// reset: positions zero, registers to their defaults, line memory left unwritten
`default_nettype none

module rgb_conv3x3_normalized
    import rgbc3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [23:0]       cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel_red, pixel_green, pixel_blue
    input  wire logic [PIX_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // center_row, center_col, out_red, out_green, out_blue, zero pad
    output logic [DATA_W-1:0]      m_axis_tdata,
    // divide_by_zero
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        norm_reg;
    logic [23:0] krow_reg [3];

    state_t state_reg, state_next;

    logic [CW-1:0]    col_pos_reg, c_cur_reg;
    logic [ROW_W-1:0] row_pos_reg, r_cur_reg;
    logic [PIX_W-1:0] pix_reg;

    logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0]   win_reg [3][3];

    logic [3:0] mask_reg;
    logic [1:0] idx_reg, ki_reg, kj_reg;
    logic [4:0] step_reg;

    logic signed [CH_W-1:0] sum_reg [3];
    logic signed [11:0]     ksum_reg;
    logic [18:0]            quo_reg [3];
    logic [10:0]            rem_reg [3];
    logic [2:0]             neg_reg;
    logic [10:0]            dvs_reg;
    logic [CH_W-1:0]        res_reg [3];
    logic                   dbz_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] tdata_reg;
    logic              tuser_reg, tlast_reg;

    // frame size limits
    logic [12:0]   w13;
    logic [13:0]   h14;
    logic [CW-1:0] w_eff;
    logic [12:0]   h_eff;

    always_comb
    begin
        w13 = {2'b00, width_reg};
        if (w13 == 13'd0)
            w13 = 13'd1;
        else if (w13 > 13'(LINE_DEPTH))
            w13 = 13'(LINE_DEPTH);
        w_eff = w13[CW-1:0];
        h14 = {1'b0, height_reg};
        if (h14 == 14'd0)
            h14 = 14'd1;
        else if (h14 > 14'd4096)
            h14 = 14'd4096;
        h_eff = h14[12:0];
    end

    // position of the incoming word
    logic [CW-1:0]    c_start;
    logic [12:0]      r_tmp;
    logic [ROW_W-1:0] r_start;

    always_comb
    begin
        c_start = col_pos_reg;
        r_tmp   = {1'b0, row_pos_reg};
        if (col_pos_reg >= w_eff)
        begin
            c_start = '0;
            r_tmp   = r_tmp + 13'd1;
        end
        if (r_tmp >= h_eff)
            r_tmp = '0;
        r_start = r_tmp[ROW_W-1:0];
    end

    // position after the current word
    logic [CW:0]      c_inc;
    logic [12:0]      r_inc;
    logic [CW-1:0]    col_after;
    logic [ROW_W-1:0] row_after;

    always_comb
    begin
        c_inc     = {1'b0, c_cur_reg} + {{CW{1'b0}}, 1'b1};
        r_inc     = {1'b0, r_cur_reg} + 13'd1;
        col_after = c_inc[CW-1:0];
        row_after = r_cur_reg;
        if (c_inc >= {1'b0, w_eff})
        begin
            col_after = '0;
            row_after = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end
    end

    // centres completed by the current word
    logic       rge1, cge1, rlast, clast;
    logic [3:0] mask_new;

    assign rge1     = (r_cur_reg != '0);
    assign cge1     = (c_cur_reg != '0);
    assign clast    = ({1'b0, c_cur_reg} + {{CW{1'b0}}, 1'b1}) == {1'b0, w_eff};
    assign rlast    = ({1'b0, r_cur_reg} + 13'd1) == h_eff;
    assign mask_new = {rlast & clast, rlast & cge1, rge1 & clast, rge1 & cge1};

    function automatic logic [1:0] low_bit(input logic [3:0] m);
        logic [1:0] r;
        r = 2'd3;
        if (m[2])
            r = 2'd2;
        if (m[1])
            r = 2'd1;
        if (m[0])
            r = 2'd0;
        return r;
    endfunction

    // tap selection
    logic             roff, coff, ci_zero, cj_zero, tap_ok, tap_last;
    logic [1:0]       wr, wc;
    logic [7:0]       coef;
    logic [PIX_W-1:0] tap_pix;
    logic [ROW_W-1:0] ci;
    logic [CW-1:0]    cj;

    assign roff     = idx_reg[1];
    assign coff     = idx_reg[0];
    assign wr       = ki_reg + {1'b0, roff};
    assign wc       = kj_reg + {1'b0, coff};
    assign ci_zero  = roff ? (r_cur_reg == '0) : (r_cur_reg == ROW_W'(1));
    assign cj_zero  = coff ? (c_cur_reg == '0) : (c_cur_reg == CW'(1));
    assign tap_ok   = (wr != 2'd3) && (wc != 2'd3) && !(ki_reg == 2'd0 && ci_zero)
                      && !(kj_reg == 2'd0 && cj_zero);
    assign tap_last = (ki_reg == 2'd2) && (kj_reg == 2'd2);
    assign coef     = krow_reg[ki_reg][8*kj_reg +: 8];
    assign tap_pix  = tap_ok ? win_reg[wr][wc] : '0;
    assign ci       = roff ? r_cur_reg : r_cur_reg - ROW_W'(1);
    assign cj       = coff ? c_cur_reg : c_cur_reg - CW'(1);

    logic signed [16:0]     prod [3];
    logic signed [CH_W-1:0] sum_next [3];
    logic signed [11:0]     ksum_next;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch]     = $signed(coef) * $signed({1'b0, tap_pix[8*ch +: 8]});
            sum_next[ch] = sum_reg[ch] + (tap_ok ? {{3{prod[ch][16]}}, prod[ch]} : '0);
        end
        ksum_next = ksum_reg + (tap_ok ? {{4{coef[7]}}, coef} : 12'sd0);
    end

    // one restoring division step per channel
    logic [11:0] div_trial [3];
    logic        div_ge  [3];
    logic [10:0] rem_n   [3];
    logic [18:0] quo_n   [3];
    logic [CH_W-1:0] mag [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            div_trial[ch] = {rem_reg[ch], quo_reg[ch][18]};
            div_ge[ch]    = div_trial[ch] >= {1'b0, dvs_reg};
            rem_n[ch]     = div_ge[ch] ? 11'(div_trial[ch] - {1'b0, dvs_reg})
                                       : div_trial[ch][10:0];
            quo_n[ch]     = {quo_reg[ch][17:0], div_ge[ch]};
            mag[ch]       = sum_next[ch][CH_W-1] ? -sum_next[ch] : sum_next[ch];
        end
    end

    logic       accept, out_load, start_div;
    logic [3:0] mask_rest;
    logic [11:0] kabs;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
    assign mask_rest = mask_reg & ~(4'b0001 << idx_reg);
    assign start_div = norm_reg && (ksum_next != 12'sd0);
    assign kabs      = ksum_next[11] ? -ksum_next : ksum_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_READ;
            ST_READ: state_next = (mask_new == 4'd0) ? ST_IDLE : ST_MAC;
            ST_MAC:  if (tap_last) state_next = start_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (step_reg == 5'd18) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = (mask_rest == 4'd0) ? ST_IDLE : ST_MAC;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            width_reg   <= 11'd640;
            height_reg  <= 13'd480;
            norm_reg    <= 1'b1;
            krow_reg[0] <= 24'h010201;
            krow_reg[1] <= 24'h020402;
            krow_reg[2] <= 24'h010201;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            mask_reg    <= '0;
            idx_reg     <= '0;
            ki_reg      <= '0;
            kj_reg      <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg   <= cfg_data[10:0];
                    CFG_HEIGHT: height_reg  <= cfg_data[12:0];
                    CFG_NORM:   norm_reg    <= cfg_data[0];
                    CFG_KTOP:   krow_reg[0] <= cfg_data;
                    CFG_KMID:   krow_reg[1] <= cfg_data;
                    CFG_KBOT:   krow_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_READ)
            begin
                col_pos_reg <= col_after;
                row_pos_reg <= row_after;
                mask_reg    <= mask_new;
                idx_reg     <= low_bit(mask_new);
                ki_reg      <= '0;
                kj_reg      <= '0;
            end
            if (state_reg == ST_MAC)
            begin
                step_reg <= '0;
                if (kj_reg == 2'd2)
                begin
                    kj_reg <= '0;
                    ki_reg <= ki_reg + 2'd1;
                end
                else
                    kj_reg <= kj_reg + 2'd1;
            end
            if (state_reg == ST_DIV)
                step_reg <= step_reg + 5'd1;
            if (out_load)
            begin
                mask_reg <= mask_rest;
                idx_reg  <= low_bit(mask_rest);
                ki_reg   <= '0;
                kj_reg   <= '0;
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[c_start[AW-1:0]];
            pix_reg     <= s_axis_tdata;
            c_cur_reg   <= c_start;
            r_cur_reg   <= r_start;
        end
        if (state_reg == ST_READ)
            line_mem[c_cur_reg[AW-1:0]] <= {rd_data_reg[PIX_W-1:0], pix_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= rd_data_reg[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= rd_data_reg[PIX_W-1:0];
            win_reg[2][2] <= pix_reg;
        end

        if (state_reg == ST_MAC)
        begin
            sum_reg  <= sum_next;
            ksum_reg <= ksum_next;
            if (tap_last)
            begin
                dvs_reg <= kabs[10:0];
                dbz_reg <= norm_reg && (ksum_next == 12'sd0);
                for (int ch = 0; ch < 3; ch++)
                begin
                    quo_reg[ch] <= mag[ch][18:0];
                    rem_reg[ch] <= '0;
                    neg_reg[ch] <= sum_next[ch][CH_W-1] ^ ksum_next[11];
                    res_reg[ch] <= norm_reg ? '0 : sum_next[ch];
                end
            end
        end
        else
        begin
            for (int ch = 0; ch < 3; ch++)
                sum_reg[ch] <= '0;
            ksum_reg <= '0;
        end

        if (state_reg == ST_DIV)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                quo_reg[ch] <= quo_n[ch];
                rem_reg[ch] <= rem_n[ch];
                if (step_reg == 5'd18)
                    res_reg[ch] <= neg_reg[ch] ? -{1'b0, quo_n[ch]} : {1'b0, quo_n[ch]};
            end
        end

        if (out_load)
        begin
            tdata_reg <= {6'b000000, res_reg[2], res_reg[1], res_reg[0], COL_W'(cj), ci};
            tuser_reg <= dbz_reg;
            tlast_reg <= (mask_rest == 4'd0);
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

`default_nettype wire

[rtl/rgbc3_checks.sv]
`default_nettype none

module rgbc3_checks
    import rgbc3_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]        m_axis_tuser,
    input wire logic              m_axis_tlast
);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // zero tap sum gives zero channels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[BLUE_LSB+CH_W-1:RED_LSB] == '0)
        else $error("divide by zero with nonzero channels");

    // one pixel in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DATA_W-1:BLUE_LSB+CH_W] == '0)
        else $error("pad bits set");

endmodule

bind rgb_conv3x3_normalized rgbc3_checks u_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/rgb_conv3x3_normalized_checker.sv]
`timescale 1ns / 100ps

module rgb_conv3x3_normalized_checker
    import rgbc3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [23:0]       cfg_data,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [PIX_W-1:0]  s_axis_tdata,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [DATA_W-1:0] m_axis_tdata,
    input  wire logic [0:0]        m_axis_tuser,
    input  wire logic              m_axis_tlast,
    output int                     pending,
    output int                     fails
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             dz;
        logic             last;
    } conv_result_t;

    conv_result_t expected_conv[$];

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        norm_reg;
    logic [23:0] kern[3];

    // pixels kept with red in bits 7:0, green 15:8, blue 23:16
    logic [23:0] upper_line[LINE_DEPTH];
    logic [23:0] lower_line[LINE_DEPTH];
    logic [23:0] win[3][3];
    int          row_pos;
    int          col_pos;

    function automatic conv_result_t conv_at(int ci, int cj, int r, int c, int w, int h);
        int sum[3];
        int ksum;
        int y;
        int x;
        int k;
        logic [23:0] px;
        conv_result_t res;
        sum = '{0, 0, 0};
        ksum = 0;
        for (int ki = 0; ki < 3; ki++)
        begin
            for (int kj = 0; kj < 3; kj++)
            begin
                y = ci - 1 + ki;
                x = cj - 1 + kj;
                if (y >= 0 && y < h && x >= 0 && x < w &&
                    y >= r - 2 && y <= r && x >= c - 2 && x <= c)
                begin
                    px = win[y - (r - 2)][x - (c - 2)];
                    k = $signed(kern[ki][8*kj +: 8]);
                    ksum += k;
                    for (int ch = 0; ch < 3; ch++)
                        sum[ch] += k * int'(px[8*ch +: 8]);
                end
            end
        end
        res.dz = 1'b0;
        if (norm_reg)
        begin
            if (ksum == 0)
            begin
                res.dz = 1'b1;
                sum = '{0, 0, 0};
            end
            else
            begin
                for (int ch = 0; ch < 3; ch++)
                    sum[ch] = sum[ch] / ksum;
            end
        end
        res.row = ci[ROW_W-1:0];
        res.col = cj[COL_W-1:0];
        res.red = sum[0][CH_W-1:0];
        res.green = sum[1][CH_W-1:0];
        res.blue = sum[2][CH_W-1:0];
        res.last = 1'b0;
        return res;
    endfunction

    task automatic predict_pixel(input logic [23:0] pix);
        int w;
        int h;
        int r;
        int c;
        conv_result_t res[$];
        w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH ? LINE_DEPTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : int'(height_reg));
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = pix;
        upper_line[c] = lower_line[c];
        lower_line[c] = pix;
        if (r >= 1 && c >= 1)
            res.push_back(conv_at(r - 1, c - 1, r, c, w, h));
        if (r >= 1 && c == w - 1)
            res.push_back(conv_at(r - 1, c, r, c, w, h));
        if (r == h - 1 && c >= 1)
            res.push_back(conv_at(r, c - 1, r, c, w, h));
        if (r == h - 1 && c == w - 1)
            res.push_back(conv_at(r, c, r, c, w, h));
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_conv.push_back(res[i]);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t e;
        if (!rst_n)
        begin
            width_reg <= 11'd640;
            height_reg <= 13'd480;
            norm_reg <= 1'b1;
            kern[0] <= 24'h010201;
            kern[1] <= 24'h020402;
            kern[2] <= 24'h010201;
            row_pos = 0;
            col_pos = 0;
            fails = 0;
            pending = 0;
            expected_conv.delete();
            foreach (win[i, j])
                win[i][j] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg <= cfg_data[10:0];
                    CFG_HEIGHT: height_reg <= cfg_data[12:0];
                    CFG_NORM:   norm_reg <= cfg_data[0];
                    CFG_KTOP:   kern[0] <= cfg_data;
                    CFG_KMID:   kern[1] <= cfg_data;
                    CFG_KBOT:   kern[2] <= cfg_data;
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_conv.size() == 0)
                begin
                    $error("unexpected result word: %0h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    e = expected_conv.pop_front();
                    check_field("center_row", e.row, m_axis_tdata[ROW_LSB +: ROW_W]);
                    check_field("center_col", e.col, m_axis_tdata[COL_LSB +: COL_W]);
                    check_field("out_red", e.red, m_axis_tdata[RED_LSB +: CH_W]);
                    check_field("out_green", e.green, m_axis_tdata[GREEN_LSB +: CH_W]);
                    check_field("out_blue", e.blue, m_axis_tdata[BLUE_LSB +: CH_W]);
                    check_field("divide_by_zero", e.dz, m_axis_tuser[0]);
                    check_field("last_of_run", e.last, m_axis_tlast);
                end
            end
            pending = expected_conv.size();
        end
    end

endmodule

[tb/rgb_conv3x3_normalized_tb.sv]
`timescale 1ns / 100ps

module rgb_conv3x3_normalized_tb
    import rgbc3_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [23:0]       cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [PIX_W-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              m_axis_tlast;
    int                pending;
    int                fails;

    int cycles = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int rand_pixels = 0;

    rgb_conv3x3_normalized dut (.*);

    rgb_conv3x3_normalized_checker checker_i (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls: a ready mode picked at random, plus long holds on request
    int rx_mode = 0;
    int rx_count = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 50 == 0)
            rx_mode = $urandom_range(0, 2);
        if (hold_left == 0 && holds_served < hold_requests)
        begin
            holds_served++;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_axis_tready <= 1'b1;
        else if (rx_mode == 1)
            m_axis_tready <= $urandom_range(0, 1);
        else
            m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_frame(input logic [10:0] w, input logic [12:0] h, input logic norm,
                               input logic [23:0] kt, input logic [23:0] km,
                               input logic [23:0] kb);
        write_reg(CFG_WIDTH, 24'(w));
        write_reg(CFG_HEIGHT, 24'(h));
        write_reg(CFG_NORM, 24'(norm));
        write_reg(CFG_KTOP, kt);
        write_reg(CFG_KMID, km);
        write_reg(CFG_KBOT, kb);
    endtask

    task automatic send_word(input logic [23:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // extremes alternate all-zero and all-one words
    task automatic send_frame(input int n, input bit extremes);
        for (int i = 0; i < n; i++)
            send_word(extremes ? ((i % 2) ? 24'hFFFFFF : 24'h000000) : 24'($urandom));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int w;
        int h;
        int frame_no;
        logic [23:0] kt;
        logic [23:0] km;
        logic [23:0] kb;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sizes act as one pixel
        setup_frame(11'd0, 13'd0, 1'b1, 24'h010201, 24'h020402, 24'h010201);
        send_frame(1, 1);
        wait_idle();
        // most negative kernel, normalized
        setup_frame(11'd3, 13'd3, 1'b1, 24'h808080, 24'h808080, 24'h808080);
        send_frame(9, 1);
        wait_idle();
        // zero tap sum
        setup_frame(11'd3, 13'd2, 1'b1, 24'h00FF01, 24'h000000, 24'h000000);
        send_frame(6, 1);
        wait_idle();
        // most positive kernel, raw sums; unknown indexes ignored
        setup_frame(11'd2, 13'd3, 1'b0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        write_reg(cfg_idx_t'(3'd6), 24'hFFFFFF);
        write_reg(cfg_idx_t'(3'd7), 24'hFFFFFF);
        send_frame(6, 1);
        wait_idle();

        frame_no = 0;
        while (rand_pixels < 200)
        begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 7);
            if ($urandom_range(0, 4) == 0)
            begin
                kt = 24'h00FF01;
                km = 24'($urandom_range(0, 1) ? 24'h0101FE : 24'h000000);
                kb = 24'h000000;
            end
            else
            begin
                kt = 24'($urandom);
                km = 24'($urandom);
                kb = 24'($urandom);
            end
            setup_frame(11'(w), 13'(h), 1'($urandom_range(0, 1)), kt, km, kb);
            if (frame_no == 2 || frame_no == 7)
                hold_requests++;
            send_frame(w * h, 0);
            rand_pixels += w * h;
            frame_no++;
            wait_idle();
        end

        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
